// ===== src/ctr_pkg.sv =====
// Package: shared types and constants for the chunked transfer receiver.
`timescale 1ns / 1ps
package ctr_pkg;

  localparam int ChunkCountDefault = 20;
  localparam int ReadsPerChunk     = 3;

  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_PROBE = 3'd1,
    CMD_START = 3'd2,
    CMD_DATA  = 3'd3,
    CMD_END   = 3'd4,
    CMD_ABORT = 3'd5,
    CMD_RSV6  = 3'd6,
    CMD_RSV7  = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_REPLY = 2'd0,
    KIND_READY = 2'd1,
    KIND_ACK   = 2'd2,
    KIND_READ  = 2'd3
  } kind_t;

  localparam logic [1:0] REG_OWN_ID   = 2'd0;
  localparam logic [1:0] REG_CONTACT  = 2'd1;
  localparam logic [1:0] REG_IDLE     = 2'd2;
  localparam logic [1:0] REG_INTERVAL = 2'd3;

  // One queued job from the front part to the back part.
  typedef struct packed {
    logic        has_sig;   // reply, ready or ack to send
    kind_t       kind;
    logic [15:0] seq;
    logic [15:0] sess;
    logic [7:0]  chk;
    logic        dump;      // dump all readings after the signal word
    logic        peer;
    logic        act;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_SIG  = 2'd1,
    BK_RD   = 2'd2,
    BK_DUMP = 2'd3
  } bk_state_t;

endpackage

// ===== src/ctr_front.sv =====
// Front part: decodes words, keeps session state, writes stores, queues jobs.
`timescale 1ns / 1ps
module ctr_front
  import ctr_pkg::*;
#(
  parameter int CHUNK_COUNT = ChunkCountDefault,
  parameter int AW          = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_sel,
  input  logic          cfg_hit,
  input  logic [15:0]   cfg_wdata,
  input  logic          acc,
  input  logic [2:0]    cmd,
  input  logic [15:0]   src_id,
  input  logic [15:0]   probe_seq,
  input  logic [15:0]   sess_in,
  input  logic [7:0]    chunk,
  input  logic [7:0]    chunk_total,
  input  logic [47:0]   lights,
  input  logic [47:0]   motions,
  output logic          job_push,
  output job_t          job,
  output logic          st_we,
  output logic [AW-1:0] st_wa,
  output logic [31:0]   st_wd
);

  logic [15:0] own_r;
  logic [7:0]  cto_r, ito_r, sint_r;
  logic [15:0] peer_r, sess_r;
  logic        seen_r, open_r, fcw_r, arv_r, done_r;
  logic [4:0]  arc_r;
  logic [7:0]  rsc_r;
  logic [CHUNK_COUNT-1:0] map_r;
  logic [7:0]  tp_r, ta_r, ts_r;
  // Pending store write lanes of an accepted new chunk.
  logic [1:0]  wcnt_r;
  logic [AW-1:0] wbase_r;
  logic [47:0] wl_r, wm_r;

  logic [7:0] tp, ta, ts, tick_ts;
  logic ok_data, newchk, dump_due, probe_ok, start_ok, push_want;
  logic tick_sig, tick_open, tick_seen, tick_drop;
  logic [CHUNK_COUNT-1:0] map_nxt;

  always_comb begin
    tp = (tp_r == 8'hFF) ? tp_r : tp_r + 8'd1;
    ta = (ta_r == 8'hFF) ? ta_r : ta_r + 8'd1;
    ts = (ts_r == 8'hFF) ? ts_r : ts_r + 8'd1;
    ok_data = (src_id == peer_r) && (sess_in == sess_r) &&
              (chunk_total == 8'(CHUNK_COUNT)) && (chunk < 8'(CHUNK_COUNT));
    newchk = ok_data && !map_r[chunk[4:0]];
    map_nxt = map_r;
    map_nxt[chunk[4:0]] = 1'b1;
    dump_due = !done_r && (&map_nxt);
    probe_ok = (src_id != own_r) && (src_id == peer_r || peer_r == 16'd0);
    start_ok = (src_id == peer_r || peer_r == 16'd0) &&
               (chunk_total == 8'(CHUNK_COUNT));
    // A tick may repeat a signal word and then still drop the session.
    tick_sig = open_r && (ts >= sint_r) && (fcw_r || arv_r);
    tick_drop = open_r && (ta > ito_r);
    tick_ts = tick_sig ? 8'd0 : ts;
    tick_open = open_r;
    tick_seen = seen_r;
    if (seen_r && !open_r && tp > cto_r) tick_seen = 1'b0;
    if (tick_drop) begin
      tick_open = 1'b0;
      tick_seen = 1'b0;
      tick_ts = 8'hFF;
    end
    unique case (cmd_t'(cmd))
      CMD_TICK:  push_want = tick_sig;
      CMD_PROBE: push_want = probe_ok;
      CMD_START: push_want = start_ok;
      CMD_DATA:  push_want = ok_data;
      default:   push_want = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_r <= '0; cto_r <= 8'd30; ito_r <= 8'd80; sint_r <= 8'd1;
      peer_r <= '0; sess_r <= '0; seen_r <= 1'b0; open_r <= 1'b0;
      fcw_r <= 1'b0; arv_r <= 1'b0; done_r <= 1'b0; arc_r <= '0;
      rsc_r <= '0; map_r <= '0; tp_r <= '0; ta_r <= '0; ts_r <= 8'hFF;
      job_push <= 1'b0; wcnt_r <= '0;
    end else begin
      job_push <= acc && push_want;
      if (acc && cmd_t'(cmd) == CMD_DATA && newchk) begin
        wcnt_r <= 2'd3;
        wbase_r <= AW'(chunk) * AW'(ReadsPerChunk);
        wl_r <= lights; wm_r <= motions;
      end else if (wcnt_r != 2'd0) begin
        wcnt_r  <= wcnt_r - 2'd1;
        wl_r    <= wl_r >> 16;
        wm_r    <= wm_r >> 16;
        wbase_r <= wbase_r + AW'(1);
      end
      if (cfg_we && cfg_hit) begin
        unique case (cfg_sel)
          REG_OWN_ID:   own_r  <= cfg_wdata;
          REG_CONTACT:  cto_r  <= cfg_wdata[7:0];
          REG_IDLE:     ito_r  <= cfg_wdata[7:0];
          REG_INTERVAL: sint_r <= cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (acc) begin
        unique case (cmd_t'(cmd))
          CMD_TICK: begin
            tp_r <= tp; ta_r <= ta; ts_r <= tick_ts;
            open_r <= tick_open; seen_r <= tick_seen;
            if (tick_drop) begin
              fcw_r <= 1'b0; arv_r <= 1'b0; sess_r <= '0;
            end
            job <= '{has_sig: tick_sig, kind: fcw_r ? KIND_READY : KIND_ACK,
                     seq: '0, sess: sess_r,
                     chk: fcw_r ? rsc_r : {3'b0, arc_r}, dump: 1'b0,
                     peer: tick_seen, act: tick_open};
          end
          CMD_PROBE: begin
            if (probe_ok) begin
              if (peer_r == 16'd0) peer_r <= src_id;
              if (!open_r) seen_r <= 1'b1;
              tp_r <= '0;
              job <= '{has_sig: 1'b1, kind: KIND_REPLY, seq: probe_seq,
                       sess: '0, chk: '0, dump: 1'b0,
                       peer: open_r ? seen_r : 1'b1, act: open_r};
            end
          end
          CMD_START: begin
            if (peer_r == 16'd0) peer_r <= src_id;
            if (start_ok) begin
              seen_r <= 1'b1; open_r <= 1'b1; sess_r <= sess_in;
              rsc_r <= chunk; fcw_r <= 1'b1; arv_r <= 1'b0;
              ta_r <= '0; ts_r <= '0;
              job <= '{has_sig: 1'b1, kind: KIND_READY, seq: '0,
                       sess: sess_in, chk: chunk, dump: 1'b0,
                       peer: 1'b1, act: 1'b1};
            end
          end
          CMD_DATA: begin
            if (ok_data) begin
              fcw_r <= 1'b0; open_r <= 1'b1; ta_r <= '0; arv_r <= 1'b1;
              arc_r <= chunk[4:0]; ts_r <= '0;
              if (newchk) map_r <= map_nxt;
              if (dump_due) done_r <= 1'b1;
              job <= '{has_sig: 1'b1, kind: KIND_ACK, seq: '0,
                       sess: sess_r, chk: chunk, dump: dump_due,
                       peer: seen_r, act: 1'b1};
            end
          end
          CMD_END, CMD_ABORT: begin
            if (src_id == peer_r && sess_in == sess_r) begin
              open_r <= 1'b0; fcw_r <= 1'b0; arv_r <= 1'b0;
              sess_r <= '0; ts_r <= 8'hFF; seen_r <= 1'b0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign st_we = (wcnt_r != 2'd0);
  assign st_wa = wbase_r;
  assign st_wd = {wl_r[15:0], wm_r[15:0]};

endmodule

// ===== src/ctr_back.sv =====
// Back part: job queue, reading store, and result word sequencer.
`timescale 1ns / 1ps
module ctr_back
  import ctr_pkg::*;
#(
  parameter int RD_TOTAL = ChunkCountDefault * ReadsPerChunk,
  parameter int AW       = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_push,
  input  job_t          job,
  output logic          q_full,
  input  logic          st_we,
  input  logic [AW-1:0] st_wa,
  input  logic [31:0]   st_wd,
  output logic          out_empty,
  input  logic          out_pop,
  output logic [1:0]    out_kind,
  output logic [15:0]   out_reply_seq,
  output logic [15:0]   out_out_session,
  output logic [7:0]    out_out_chunk,
  output logic [5:0]    out_reading_index,
  output logic [15:0]   out_light_value,
  output logic [15:0]   out_motion_value,
  output logic          out_last,
  output logic          out_peer_up,
  output logic          out_session_active
);

  logic [31:0] mem [RD_TOTAL];
  logic [31:0] rd_r;

  // Two-entry job queue.
  job_t q_r [2];
  logic [1:0] cnt_r;
  logic wp_r, rp_r;
  logic take;

  bk_state_t st_r, st_nxt;
  job_t cur_r;
  logic [AW-1:0] idx_r;
  logic ovalid_r;

  assign q_full = (cnt_r != 2'd0);  // a waiting job holds off the next word
  assign out_empty = !ovalid_r;

  always_ff @(posedge clk) begin
    if (st_we) mem[st_wa] <= st_wd;
    rd_r <= mem[idx_r];
  end

  always_comb begin
    take = (st_r == BK_IDLE) && (cnt_r != 2'd0) && !ovalid_r;
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      BK_IDLE: if (take) st_nxt = BK_SIG;
      BK_SIG: if (!ovalid_r) st_nxt = cur_r.dump ? BK_RD : BK_IDLE;
      BK_RD:  st_nxt = BK_DUMP;
      BK_DUMP: if (!ovalid_r)
        st_nxt = (idx_r == AW'(RD_TOTAL - 1)) ? BK_IDLE : BK_RD;
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE; cnt_r <= '0; wp_r <= 1'b0; rp_r <= 1'b0;
      ovalid_r <= 1'b0; idx_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (job_push) begin
        q_r[wp_r] <= job;
        wp_r <= ~wp_r;
      end
      cnt_r <= cnt_r + {1'b0, job_push} - {1'b0, take};
      if (take) begin
        cur_r <= q_r[rp_r];
        rp_r <= ~rp_r;
        idx_r <= '0;
      end
      if (ovalid_r && out_pop) ovalid_r <= 1'b0;
      unique case (st_r)
        BK_SIG: if (!ovalid_r) begin
          if (cur_r.has_sig) ovalid_r <= 1'b1;
          out_kind <= cur_r.kind; out_reply_seq <= cur_r.seq;
          out_out_session <= cur_r.sess; out_out_chunk <= cur_r.chk;
          out_reading_index <= '0; out_light_value <= '0; out_motion_value <= '0;
          out_last <= !cur_r.dump;
          out_peer_up <= cur_r.peer; out_session_active <= cur_r.act;
        end
        BK_DUMP: if (!ovalid_r) begin
          ovalid_r <= 1'b1;
          out_kind <= KIND_READ; out_reply_seq <= '0; out_out_session <= '0;
          out_out_chunk <= '0; out_reading_index <= 6'(idx_r);
          out_light_value <= rd_r[31:16]; out_motion_value <= rd_r[15:0];
          out_last <= (idx_r == AW'(RD_TOTAL - 1));
          idx_r <= idx_r + AW'(1);
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== src/chunked_transfer_receiver_unit.sv =====
// Top level of the chunked transfer receiver.
//   channel | direction | handshake        | payload
//   in      | input     | push / full      | cmd, ids, chunk, six readings
//   out     | output    | pop / empty      | kind .. session_active
//   cfg     | input     | we, idx, wdata   | four registers
// The front part registers the job of each word it takes; the back part
// queues the job, picks it up and registers its first result word. A word
// that queues a job holds off the next one until the back part has picked
// the job up, and no two words are taken back to back. A dump reads each
// reading from the store, then outputs it. Reset is synchronous and clears
// all control state; the reading store is not cleared. A stalled output
// stalls the back part, the queued job then waits and the input stays full.
`timescale 1ns / 1ps
module chunked_transfer_receiver_unit
  import ctr_pkg::*;
#(
  parameter int CHUNK_COUNT = ChunkCountDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [15:0] cfg_wdata,
  input  logic        in_push,
  output logic        in_full,
  input  logic [2:0]  in_cmd,
  input  logic [15:0] in_src_id,
  input  logic [15:0] in_probe_seq,
  input  logic [15:0] in_sess,
  input  logic [7:0]  in_chunk,
  input  logic [7:0]  in_chunk_total,
  input  logic [15:0] in_light_0,
  input  logic [15:0] in_light_1,
  input  logic [15:0] in_light_2,
  input  logic [15:0] in_motion_0,
  input  logic [15:0] in_motion_1,
  input  logic [15:0] in_motion_2,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_kind,
  output logic [15:0] out_reply_seq,
  output logic [15:0] out_out_session,
  output logic [7:0]  out_out_chunk,
  output logic [5:0]  out_reading_index,
  output logic [15:0] out_light_value,
  output logic [15:0] out_motion_value,
  output logic        out_last,
  output logic        out_peer_up,
  output logic        out_session_active
);

  localparam int RdTotal = CHUNK_COUNT * ReadsPerChunk;
  localparam int Aw = $clog2(RdTotal);

  logic job_push, q_full, st_we, busy_r;
  job_t job;
  logic [Aw-1:0] st_wa;
  logic [31:0] st_wd;
  logic acc;

  // Hold input in the cycle after each word so the queue state is settled.
  assign in_full = q_full || job_push || busy_r;
  assign acc = in_push && !in_full;

  always_ff @(posedge clk) begin
    if (!rst_n) busy_r <= 1'b0;
    else        busy_r <= acc;
  end

  ctr_front #(.CHUNK_COUNT(CHUNK_COUNT), .AW(Aw)) u_front (
    .clk, .rst_n, .cfg_we, .cfg_sel(cfg_idx[1:0]), .cfg_hit(!cfg_idx[2]),
    .cfg_wdata, .acc, .cmd(in_cmd), .src_id(in_src_id),
    .probe_seq(in_probe_seq), .sess_in(in_sess), .chunk(in_chunk),
    .chunk_total(in_chunk_total),
    .lights({in_light_2, in_light_1, in_light_0}),
    .motions({in_motion_2, in_motion_1, in_motion_0}),
    .job_push, .job, .st_we, .st_wa, .st_wd
  );

  ctr_back #(.RD_TOTAL(RdTotal), .AW(Aw)) u_back (
    .clk, .rst_n, .job_push, .job, .q_full, .st_we, .st_wa, .st_wd,
    .out_empty, .out_pop, .out_kind, .out_reply_seq, .out_out_session,
    .out_out_chunk, .out_reading_index, .out_light_value, .out_motion_value,
    .out_last, .out_peer_up, .out_session_active
  );

endmodule

// ===== src/ctr_checker.sv =====
// Port-level checker for the chunked transfer receiver, bound to the top.
`timescale 1ns / 1ps
module ctr_checker
  import ctr_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_push,
  input logic       in_full,
  input logic       out_empty,
  input logic       out_pop,
  input logic [1:0] out_kind,
  input logic       out_last,
  input logic       out_session_active
);

  a_word_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> !out_empty)
    else $error("result word dropped while stalled");

  a_reply_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_kind == KIND_REPLY) |-> out_last)
    else $error("reply word not last");

  // Readings come only from a data word, which always leaves the session open.
  a_read_active: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_kind == KIND_READ) |-> out_session_active)
    else $error("reading word without open session");

  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full) |=> in_full)
    else $error("input taken on consecutive cycles");

endmodule

bind chunked_transfer_receiver_unit ctr_checker u_ctr_checker (
  .clk, .rst_n, .in_push, .in_full, .out_empty, .out_pop, .out_kind,
  .out_last, .out_session_active
);
